// ===== hdl/q16div_pkg.sv =====
package q16div_pkg;

   // Status codes of a result word
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_DIVZERO  = 2'd2;

   // Q16.16 constants
   localparam logic [31:0] MOST_NEG   = 32'h8000_0000;
   localparam int          QBITS      = 32;   // quotient bits, one per step stage
   localparam int          FRONT_DEPTH = 2;
   localparam int          BACK_DEPTH  = 2;
   localparam int          LATENCY    = FRONT_DEPTH + QBITS + BACK_DEPTH;

   typedef struct packed {
      logic signed [31:0] dividend;
      logic signed [31:0] divisor;
   } req_type;

   typedef struct packed {
      logic signed [31:0] quotient;
      logic [1:0]         status;
   } rsp_type;

   // Word carried down the divider pipeline
   typedef struct packed {
      logic        neg;      // result sign
      logic [1:0]  status;   // error seen so far
      logic [31:0] dmag;     // divisor magnitude, up to 2^31
      logic [31:0] rem;      // partial remainder, below dmag while status is OK
      logic [31:0] work;     // dividend bits still to shift out, quotient bits shifted in
   } stage_type;

endpackage

// ===== hdl/q16div_front.sv =====
module q16div_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  q16div_pkg::req_type   up_req,
   output logic                  dn_valid,
   output q16div_pkg::stage_type dn_stage
);

   typedef struct packed {
      logic        neg;
      logic        zero;
      logic [31:0] amag;
      logic [31:0] dmag;
   } mag_type;

   logic                  s1_valid_ff;
   mag_type               s1_ff, s1_in;
   logic                  s2_valid_ff;
   q16div_pkg::stage_type s2_ff, s2_in;
   logic                  too_big;

   // Take magnitudes; 0x80000000 maps to 2^31 unchanged
   always_comb begin
      s1_in.neg  = up_req.dividend[31] ^ up_req.divisor[31];
      s1_in.zero = (up_req.divisor == 32'sd0);
      s1_in.amag = up_req.dividend[31] ? 32'd0 - 32'(up_req.dividend)
                                       : 32'(up_req.dividend);
      s1_in.dmag = up_req.divisor[31] ? 32'd0 - 32'(up_req.divisor)
                                      : 32'(up_req.divisor);
   end

   // Upper 17 bits of |a|<<17 against the divisor: quotient needs 33+ bits
   assign too_big = {15'd0, s1_ff.amag[31:15]} >= s1_ff.dmag;

   always_comb begin
      s2_in.neg  = s1_ff.neg;
      s2_in.dmag = s1_ff.dmag;
      s2_in.rem  = {15'd0, s1_ff.amag[31:15]};
      s2_in.work = {s1_ff.amag[14:0], 17'd0};
      priority if (s1_ff.zero) begin
         s2_in.status = q16div_pkg::ST_DIVZERO;
      end else if (too_big) begin
         s2_in.status = q16div_pkg::ST_OVERFLOW;
      end else begin
         s2_in.status = q16div_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= up_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign dn_valid = s2_valid_ff;
   assign dn_stage = s2_ff;

endmodule

// ===== hdl/q16div_step.sv =====
module q16div_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  q16div_pkg::stage_type up_stage,
   output logic                  dn_valid,
   output q16div_pkg::stage_type dn_stage
);

   logic                  valid_ff;
   q16div_pkg::stage_type stage_ff, stage_in;
   logic [32:0]           trial;
   logic [32:0]           diff;

   // One restoring step: shift in the next dividend bit, trial subtract
   assign trial = {up_stage.rem, up_stage.work[31]};
   assign diff  = trial - {1'b0, up_stage.dmag};

   always_comb begin
      stage_in      = up_stage;
      stage_in.work = {up_stage.work[30:0], ~diff[32]};
      stage_in.rem  = diff[32] ? trial[31:0] : diff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign dn_valid = valid_ff;
   assign dn_stage = stage_ff;

endmodule

// ===== hdl/q16div_round.sv =====
module q16div_round (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  q16div_pkg::stage_type up_stage,
   output logic                  dn_valid,
   output q16div_pkg::rsp_type   dn_rsp
);

   logic                valid_a_ff;
   logic                neg_a_ff;
   logic [1:0]          status_a_ff, status_a_in;
   logic [31:0]         mag_a_ff, mag_a_in;
   logic                valid_b_ff;
   q16div_pkg::rsp_type rsp_b_ff, rsp_b_in;

   // Round half away from zero; an all-ones quotient rounds to 2^31
   always_comb begin
      mag_a_in = {1'b0, up_stage.work[31:1]} + {31'd0, up_stage.work[0]};
      priority if (up_stage.status == q16div_pkg::ST_OK && (&up_stage.work)) begin
         status_a_in = q16div_pkg::ST_OVERFLOW;
      end else begin
         status_a_in = up_stage.status;
      end
   end

   // Apply sign, or force the most negative value on error
   always_comb begin
      rsp_b_in.status = status_a_ff;
      priority if (status_a_ff != q16div_pkg::ST_OK) begin
         rsp_b_in.quotient = q16div_pkg::MOST_NEG;
      end else if (neg_a_ff) begin
         rsp_b_in.quotient = 32'd0 - mag_a_ff;
      end else begin
         rsp_b_in.quotient = mag_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= up_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      neg_a_ff    <= up_stage.neg;
      status_a_ff <= status_a_in;
      mag_a_ff    <= mag_a_in;
      rsp_b_ff    <= rsp_b_in;
   end

   assign dn_valid = valid_b_ff;
   assign dn_rsp   = rsp_b_ff;

endmodule

// ===== hdl/q16_16_signed_divider_unit.sv =====
// Channel   Ports                   Direction  Handshake
// request   start, busy, req_word   in         word taken when start && !busy
// response  rsp_strobe, rsp_word    out        word valid for the one strobe cycle
//
// From the accepting edge to the strobe a word passes two front stages
// (magnitudes, then range check), 32 restoring steps at one quotient bit per
// stage, two back stages (rounding, then sign). A new word can enter every cycle outside reset.
// Reset clears every valid bit; busy is high only during reset.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module q16_16_signed_divider_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  q16div_pkg::req_type req_word,
   output logic                rsp_strobe,
   output q16div_pkg::rsp_type rsp_word
);

   logic                  accept;
   logic                  step_valid [q16div_pkg::QBITS+1];
   q16div_pkg::stage_type step_stage [q16div_pkg::QBITS+1];

   // Take a word whenever start is high outside reset
   assign busy   = reset;
   assign accept = start && !busy;

   // Form magnitudes, sign and early errors
   q16div_front u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (accept),
      .up_req   (req_word),
      .dn_valid (step_valid[0]),
      .dn_stage (step_stage[0])
   );

   // Advance one quotient bit per stage, MSB first
   for (genvar i = 0; i < q16div_pkg::QBITS; i++) begin : g_step
      q16div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .up_valid (step_valid[i]),
         .up_stage (step_stage[i]),
         .dn_valid (step_valid[i+1]),
         .dn_stage (step_stage[i+1])
      );
   end

   // Round, catch the last overflow case, apply sign
   q16div_round u_round (
      .clock    (clock),
      .reset    (reset),
      .up_valid (step_valid[q16div_pkg::QBITS]),
      .up_stage (step_stage[q16div_pkg::QBITS]),
      .dn_valid (rsp_strobe),
      .dn_rsp   (rsp_word)
   );

   // Every accepted word comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(q16div_pkg::LATENCY) rsp_strobe)
      else $error("accepted word did not come out on time");

   // No strobe without a word accepted the fixed latency earlier
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, q16div_pkg::LATENCY))
      else $error("strobe without a matching request");

   // A zero divisor always reports division by zero
   a_divzero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.divisor == 32'sd0)
      |-> ##(q16div_pkg::LATENCY) (rsp_word.status == q16div_pkg::ST_DIVZERO))
      else $error("zero divisor not flagged");

   // Errors force the most negative quotient
   a_err_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status != q16div_pkg::ST_OK)
      |-> (rsp_word.quotient == q16div_pkg::MOST_NEG))
      else $error("error word with wrong quotient");

   // A good result never equals the most negative value, and status 3 never shows
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.status != 2'd3 &&
                      !(rsp_word.status == q16div_pkg::ST_OK &&
                        rsp_word.quotient == q16div_pkg::MOST_NEG)))
      else $error("result word out of range");

endmodule
